// ----- src/lr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg: line rasterizer shared definitions
// Item mode codes and the fixed color field width.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COLOR_BITS = 2;

  typedef logic [COLOR_BITS-1:0] color_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

endpackage
`default_nettype wire

// ----- src/lr_out_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lr_out_reg: result output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module lr_out_reg #(
  parameter int WIDTH = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic [WIDTH-1:0] data_in,
  input  wire logic             stall,
  output logic                  valid,
  output logic      [WIDTH-1:0] data,
  output logic                  free
);

  // space for a new word this cycle: empty, or the held word leaves now
  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_in;
    end
  end

endmodule
`default_nettype wire

// ----- src/lr_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lr_step: line state and Bresenham step
// Loads a line from its endpoints, or emits the current pixel and steps.
// ----------------------------------------------------------------------------
module lr_step #(
  parameter int COORD_BITS  = 10,
  parameter int SCREEN_SIZE = 800
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire logic                  mode,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_stop,
  input  wire logic [COORD_BITS-1:0] y_stop,
  input  wire lr_pkg::color_t        line_color,
  output logic                       busy,
  output logic                       emit,
  output logic      [COORD_BITS-1:0] pixel_x,
  output logic      [COORD_BITS-1:0] pixel_y,
  output lr_pkg::color_t             pixel_color,
  output logic                       visible,
  output logic                       last
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 2;
  localparam int P = COORD_BITS + 1;

  logic [C-1:0]        cur_x, cur_y, major_delta, minor_delta;
  logic signed [E-1:0] err_term;
  logic [P-1:0]        pixels_left;
  logic                steep, x_dir_neg, y_dir_neg;
  lr_pkg::color_t      held_color;

  logic [C-1:0]        dx, dy, ld_x, ld_y, ld_major, ld_minor;
  logic [P-1:0]        ld_left;
  logic                ld_steep, ld_xneg, ld_yneg;
  logic signed [E-1:0] ld_err, step_err;
  logic                step_minor;
  logic [C-1:0]        step_x, step_y;
  logic [31:0]         wide_x, wide_y;

  // line setup from the endpoints
  always_comb begin
    dx = (x_stop >= x_start) ? x_stop - x_start : x_start - x_stop;
    dy = (y_stop >= y_start) ? y_stop - y_start : y_start - y_stop;
    ld_xneg  = 1'b0;
    ld_yneg  = 1'b0;
    ld_x     = x_start;
    ld_y     = y_start;
    ld_major = dx;
    ld_minor = '0;
    ld_steep = 1'b0;
    ld_left  = {1'b0, dx} + P'(1);
    if (dy == '0) begin
      // horizontal: run low to high, both ends included
      ld_x = (x_start < x_stop) ? x_start : x_stop;
    end else if (dx == '0) begin
      ld_steep = 1'b1;
      ld_y     = (y_start < y_stop) ? y_start : y_stop;
      ld_major = dy;
      ld_left  = {1'b0, dy} + P'(1);
    end else begin
      ld_xneg = x_stop < x_start;
      ld_yneg = y_stop < y_start;
      if (dy <= dx) begin
        ld_minor = dy;
      end else begin
        ld_steep = 1'b1;
        ld_major = dy;
        ld_minor = dx;
      end
      // far endpoint is not drawn
      ld_left = {1'b0, ld_major};
    end
    ld_err = $signed({2'b00, ld_minor}) - $signed({2'b00, ld_major});
  end

  // one pixel step
  always_comb begin
    step_minor = !err_term[E-1];
    step_err   = err_term + $signed({2'b00, minor_delta})
                 - (step_minor ? $signed({2'b00, major_delta}) : $signed(E'(0)));
    step_x = cur_x;
    step_y = cur_y;
    if (steep) begin
      step_y = y_dir_neg ? cur_y - C'(1) : cur_y + C'(1);
      if (step_minor) begin
        step_x = x_dir_neg ? cur_x - C'(1) : cur_x + C'(1);
      end
    end else begin
      step_x = x_dir_neg ? cur_x - C'(1) : cur_x + C'(1);
      if (step_minor) begin
        step_y = y_dir_neg ? cur_y - C'(1) : cur_y + C'(1);
      end
    end
  end

  assign emit        = fire && (mode == lr_pkg::MODE_TICK) && busy;
  assign pixel_x     = cur_x;
  assign pixel_y     = cur_y;
  assign pixel_color = held_color;
  assign last        = pixels_left == P'(1);
  assign wide_x      = 32'(cur_x);
  assign wide_y      = 32'(cur_y);
  assign visible     = (cur_x != '0) && (wide_x < 32'(SCREEN_SIZE)) &&
                       (cur_y != '0) && (wide_y < 32'(SCREEN_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      err_term    <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      pixels_left <= '0;
      steep       <= 1'b0;
      x_dir_neg   <= 1'b0;
      y_dir_neg   <= 1'b0;
      held_color  <= '0;
    end else if (fire && (mode == lr_pkg::MODE_LOAD)) begin
      busy        <= 1'b1;
      cur_x       <= ld_x;
      cur_y       <= ld_y;
      err_term    <= ld_err;
      major_delta <= ld_major;
      minor_delta <= ld_minor;
      pixels_left <= ld_left;
      steep       <= ld_steep;
      x_dir_neg   <= ld_xneg;
      y_dir_neg   <= ld_yneg;
      held_color  <= line_color;
    end else if (emit) begin
      cur_x       <= step_x;
      cur_y       <= step_y;
      err_term    <= step_err;
      pixels_left <= pixels_left - P'(1);
      if (pixels_left == P'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/line_rasterizer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer_top: Bresenham line rasterizer
// A tick word is captured in the input register; on an active line its pixel
// word then loads into the output register, waiting while that one is full.
// Throughput: one input word per cycle while not stalled, one pixel per tick.
// Reset clears the line state, so ticks give no pixel until a line is loaded,
// and empties both registers.
// ----------------------------------------------------------------------------
module line_rasterizer_top #(
  parameter int COORD_BITS  = 10,
  parameter int SCREEN_SIZE = 800
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic                  mode,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_stop,
  input  wire logic [COORD_BITS-1:0] y_stop,
  input  wire lr_pkg::color_t        line_color,
  output logic                       pixel_valid,
  input  wire logic                  pixel_stall,
  output logic      [COORD_BITS-1:0] pixel_x,
  output logic      [COORD_BITS-1:0] pixel_y,
  output lr_pkg::color_t             pixel_color,
  output logic                       visible,
  output logic                       last
);

  localparam int C     = COORD_BITS;
  localparam int WIDTH = 2 * COORD_BITS + lr_pkg::COLOR_BITS + 2;

  logic                 held_valid, held_mode;
  logic [C-1:0]         held_x0, held_y0, held_x1, held_y1;
  lr_pkg::color_t       held_color;
  logic                 busy, emit, advance, out_free;
  logic [C-1:0]         step_px, step_py;
  lr_pkg::color_t       step_pc;
  logic                 step_vis, step_last;
  logic [WIDTH-1:0]     out_word;

  // a tick on an active line needs room in the output register
  assign advance    = held_valid &&
                      (out_free || held_mode == lr_pkg::MODE_LOAD || !busy);
  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held_mode  <= mode;
      held_x0    <= x_start;
      held_y0    <= y_start;
      held_x1    <= x_stop;
      held_y1    <= y_stop;
      held_color <= line_color;
    end
  end

  lr_step #(
    .COORD_BITS  (COORD_BITS),
    .SCREEN_SIZE (SCREEN_SIZE)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .mode        (held_mode),
    .x_start     (held_x0),
    .y_start     (held_y0),
    .x_stop      (held_x1),
    .y_stop      (held_y1),
    .line_color  (held_color),
    .busy        (busy),
    .emit        (emit),
    .pixel_x     (step_px),
    .pixel_y     (step_py),
    .pixel_color (step_pc),
    .visible     (step_vis),
    .last        (step_last)
  );

  lr_out_reg #(
    .WIDTH (WIDTH)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (emit),
    .data_in ({step_px, step_py, step_pc, step_vis, step_last}),
    .stall   (pixel_stall),
    .valid   (pixel_valid),
    .data    (out_word),
    .free    (out_free)
  );

  assign {pixel_x, pixel_y, pixel_color, visible, last} = out_word;

endmodule
`default_nettype wire
